// ===== hdl/assert_macros.svh =====
// Assertion macros used by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CPHU_ASSERT_IMM(LBL, CLK, RSTN, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// Next-cycle implication, checked outside reset.
`define CPHU_ASSERT_NXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

// ===== hdl/cphu_pkg.sv =====
// Package with types, widths and constants of the CT pixel to HU converter.
`default_nettype none

package cphu_pkg;

    // Datapath widths.
    localparam int RAW_W    = 16;
    localparam int SAMPLE_W = 17;
    localparam int COEF_W   = 32;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int HU_W     = 16;

    // Default number of fraction bits of slope and intercept.
    localparam int FRACTION_BITS_DEF = 16;

    // Clamp limits of the signed 16-bit result.
    localparam int HU_POS_LIMIT = 32767;
    localparam int HU_NEG_LIMIT = 32768;

    // Configuration port.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register indexes.
    typedef enum logic [2:0] {
        REG_ALLOC     = 3'd0,
        REG_STORED    = 3'd1,
        REG_SIGN      = 3'd2,
        REG_SLOPE     = 3'd3,
        REG_INTERCEPT = 3'd4
    } reg_idx_t;

    // Sample sign modes.
    typedef enum logic [1:0] {
        SIGN_UNSIGNED = 2'd0,
        SIGN_TWOS     = 2'd1
    } sign_mode_t;

    // Valid allocated bit counts and the smallest stored bit count.
    localparam logic [4:0] ALLOC_8  = 5'd8;
    localparam logic [4:0] ALLOC_16 = 5'd16;
    localparam logic [4:0] STORED_ONE = 5'd1;

    // Reset values of the registers.
    localparam logic [4:0]  ALLOC_RESET     = 5'd16;
    localparam logic [4:0]  STORED_RESET    = 5'd16;
    localparam logic [1:0]  SIGN_RESET      = 2'd0;
    localparam logic [31:0] SLOPE_RESET     = 32'h0001_0000;
    localparam logic [31:0] INTERCEPT_RESET = 32'h0000_0000;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [4:0]  alloc_bits;
        logic [4:0]  stored_bits;
        logic [1:0]  sign_mode;
        logic [31:0] slope;
        logic [31:0] intercept;
    } cphu_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/cphu_regs.sv =====
// APB configuration registers of the converter.
`default_nettype none

module cphu_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cphu_pkg::APB_AW-1:0] paddr,
    input  wire logic [cphu_pkg::APB_DW-1:0] pwdata,
    output logic      [cphu_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    output cphu_pkg::cphu_cfg_t              cfg
);
    import cphu_pkg::*;

    logic [4:0]  alloc_reg;
    logic [4:0]  stored_reg;
    logic [1:0]  sign_reg;
    logic [31:0] slope_reg;
    logic [31:0] intercept_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[4:2]);

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg     <= ALLOC_RESET;
            stored_reg    <= STORED_RESET;
            sign_reg      <= SIGN_RESET;
            slope_reg     <= SLOPE_RESET;
            intercept_reg <= INTERCEPT_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ALLOC:     alloc_reg     <= pwdata[4:0];
                REG_STORED:    stored_reg    <= pwdata[4:0];
                REG_SIGN:      sign_reg      <= pwdata[1:0];
                REG_SLOPE:     slope_reg     <= pwdata;
                REG_INTERCEPT: intercept_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        case (idx)
            REG_ALLOC:     prdata = {27'd0, alloc_reg};
            REG_STORED:    prdata = {27'd0, stored_reg};
            REG_SIGN:      prdata = {30'd0, sign_reg};
            REG_SLOPE:     prdata = slope_reg;
            REG_INTERCEPT: prdata = intercept_reg;
            default:       prdata = '0;
        endcase
    end

    assign cfg.alloc_bits  = alloc_reg;
    assign cfg.stored_bits = stored_reg;
    assign cfg.sign_mode   = sign_reg;
    assign cfg.slope       = slope_reg;
    assign cfg.intercept   = intercept_reg;

endmodule

`default_nettype wire

// ===== hdl/cphu_decode.sv =====
// First pipeline stage: sample masking, sign extension and config check.
`default_nettype none

module cphu_decode (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire cphu_pkg::cphu_cfg_t                  cfg,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [cphu_pkg::RAW_W-1:0]           raw_sample,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [cphu_pkg::SAMPLE_W-1:0]      sample,
    output logic                                      err
);
    import cphu_pkg::*;

    logic                       valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic                       err_reg;
    logic                       err_next;
    logic [RAW_W-1:0]           word;
    logic [3:0]                 top_idx;
    logic                       neg;

    assign in_ready = !valid_reg || out_ready;

    // Configuration check.
    always_comb
    begin
        err_next = ((cfg.alloc_bits != ALLOC_8) && (cfg.alloc_bits != ALLOC_16)) ||
                   (cfg.stored_bits < STORED_ONE) ||
                   (cfg.stored_bits > cfg.alloc_bits) ||
                   (cfg.sign_mode > SIGN_TWOS);
    end

    // Mask to the stored bits and extend from the top stored bit.
    always_comb
    begin
        word = raw_sample;
        if (cfg.alloc_bits == ALLOC_8)
        begin
            word[15:8] = 8'd0;
        end
        top_idx = 4'(cfg.stored_bits - STORED_ONE);
        neg     = (cfg.sign_mode == SIGN_TWOS) && word[top_idx];
        // The extra top bit always carries the sign.
        sample_next[SAMPLE_W-1] = neg;
        for (int i = 0; i < RAW_W; i++)
        begin
            if (5'(i) < cfg.stored_bits)
            begin
                sample_next[i] = word[i];
            end
            else
            begin
                sample_next[i] = neg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sample_reg <= sample_next;
            err_reg    <= err_next;
        end
    end

    assign out_valid = valid_reg;
    assign sample    = sample_reg;
    assign err       = err_reg;

endmodule

`default_nettype wire

// ===== hdl/cphu_scale.sv =====
// Second and third pipeline stages: slope multiply, then intercept add.
`default_nettype none

module cphu_scale (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire cphu_pkg::cphu_cfg_t                  cfg,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [cphu_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                                 in_err,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [cphu_pkg::ACC_W-1:0]         acc,
    output logic                                      out_err
);
    import cphu_pkg::*;

    logic                     mul_valid_reg;
    logic                     mul_ready;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     mul_err_reg;
    logic                     add_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     add_err_reg;

    assign mul_ready = !add_valid_reg || out_ready;
    assign in_ready  = !mul_valid_reg || mul_ready;

    // Slope multiply and intercept add; both operands are sign-extended first.
    always_comb
    begin
        prod_next = PROD_W'(sample) * PROD_W'($signed(cfg.slope));
        acc_next  = ACC_W'(prod_reg) + ACC_W'($signed(cfg.intercept));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                mul_valid_reg <= in_valid;
            end
            if (mul_ready)
            begin
                add_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            prod_reg    <= prod_next;
            mul_err_reg <= in_err;
        end
        if (mul_ready && mul_valid_reg)
        begin
            acc_reg     <= acc_next;
            add_err_reg <= mul_err_reg;
        end
    end

    assign out_valid = add_valid_reg;
    assign acc       = acc_reg;
    assign out_err   = add_err_reg;

endmodule

`default_nettype wire

// ===== hdl/cphu_round.sv =====
// Fourth and fifth pipeline stages: magnitude, then rounding, clamping and output.
`default_nettype none

module cphu_round #(
    parameter int FRACTION_BITS = cphu_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [cphu_pkg::ACC_W-1:0] acc,
    input  wire logic                              in_err,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [cphu_pkg::HU_W-1:0]              hu_value,
    output logic                                   saturated,
    output logic                                   config_error
);
    import cphu_pkg::*;

    localparam int RND_W = ACC_W + 1 - FRACTION_BITS;
    localparam logic [ACC_W:0]   HALF    = (ACC_W + 1)'(1) << (FRACTION_BITS - 1);
    localparam logic [RND_W-1:0] POS_LIM = RND_W'(HU_POS_LIMIT);
    localparam logic [RND_W-1:0] NEG_LIM = RND_W'(HU_NEG_LIMIT);

    logic               mag_valid_reg;
    logic               mag_ready;
    logic [ACC_W-1:0]   mag_reg;
    logic [ACC_W-1:0]   mag_next;
    logic               neg_reg;
    logic               mag_err_reg;
    logic               out_valid_reg;
    logic [HU_W-1:0]    hu_reg;
    logic [HU_W-1:0]    hu_next;
    logic               sat_reg;
    logic               sat_next;
    logic               err_reg;
    logic [ACC_W:0]     sum;
    logic [RND_W-1:0]   rounded;
    logic [RND_W-1:0]   neg_rounded;

    assign mag_ready = !out_valid_reg || out_ready;
    assign in_ready  = !mag_valid_reg || mag_ready;

    // Magnitude of the exact sum.
    always_comb
    begin
        mag_next = acc[ACC_W-1] ? (ACC_W'(0) - ACC_W'(acc)) : ACC_W'(acc);
    end

    // Round half away from zero, clamp, and force zero on a bad config.
    always_comb
    begin
        sum         = {1'b0, mag_reg} + HALF;
        rounded     = sum[ACC_W:FRACTION_BITS];
        neg_rounded = RND_W'(0) - rounded;
        sat_next    = 1'b0;
        if (mag_err_reg)
        begin
            hu_next = '0;
        end
        else if (neg_reg)
        begin
            if (rounded > NEG_LIM)
            begin
                hu_next  = NEG_LIM[HU_W-1:0];
                sat_next = 1'b1;
            end
            else
            begin
                hu_next = neg_rounded[HU_W-1:0];
            end
        end
        else
        begin
            if (rounded > POS_LIM)
            begin
                hu_next  = POS_LIM[HU_W-1:0];
                sat_next = 1'b1;
            end
            else
            begin
                hu_next = rounded[HU_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                mag_valid_reg <= in_valid;
            end
            if (mag_ready)
            begin
                out_valid_reg <= mag_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mag_reg     <= mag_next;
            neg_reg     <= acc[ACC_W-1];
            mag_err_reg <= in_err;
        end
        if (mag_ready && mag_valid_reg)
        begin
            hu_reg  <= hu_next;
            sat_reg <= sat_next;
            err_reg <= mag_err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hu_value     = hu_reg;
    assign saturated    = sat_reg;
    assign config_error = err_reg;

endmodule

`default_nettype wire

// ===== hdl/ct_pixel_to_hu_converter.sv =====
// Throughput: one sample per cycle unless m_tready stalls the output; the five
// register stages are decode, slope multiply, intercept add, magnitude, and
// round/clamp. A result waiting on m_tready holds its own stage; earlier stages
// keep filling while they have an empty slot, and s_tready falls once all are full.
// Reset empties the pipeline and loads the register defaults (16/16 bits, unsigned,
// slope 1.0, intercept 0).
`default_nettype none
`include "assert_macros.svh"

module ct_pixel_to_hu_converter #(
    parameter int FRACTION_BITS = cphu_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Input stream; s_tdata: [15:0] raw_sample.
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [15:0]                 s_tdata,
    // Output stream; m_tdata: [15:0] hu_value.
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [15:0]                      m_tdata,
    // m_tuser: [0] saturated, [1] config_error.
    output logic [1:0]                       m_tuser,
    // Configuration port.
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cphu_pkg::APB_AW-1:0] paddr,
    input  wire logic [cphu_pkg::APB_DW-1:0] pwdata,
    output logic      [cphu_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);
    import cphu_pkg::*;

    cphu_cfg_t                  cfg;
    logic                       dec_valid;
    logic                       dec_ready;
    logic signed [SAMPLE_W-1:0] dec_sample;
    logic                       dec_err;
    logic                       scl_valid;
    logic                       scl_ready;
    logic signed [ACC_W-1:0]    scl_acc;
    logic                       scl_err;

    cphu_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cphu_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .raw_sample (s_tdata),
        .out_valid  (dec_valid),
        .out_ready  (dec_ready),
        .sample     (dec_sample),
        .err        (dec_err)
    );

    cphu_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .sample    (dec_sample),
        .in_err    (dec_err),
        .out_valid (scl_valid),
        .out_ready (scl_ready),
        .acc       (scl_acc),
        .out_err   (scl_err)
    );

    cphu_round #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_round (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (scl_valid),
        .in_ready     (scl_ready),
        .acc          (scl_acc),
        .in_err       (scl_err),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .hu_value     (m_tdata),
        .saturated    (m_tuser[0]),
        .config_error (m_tuser[1])
    );

    // A bad configuration always yields a plain zero result.
    `CPHU_ASSERT_IMM(a_err_zero, clk, rst_n, m_tvalid && m_tuser[1], (m_tdata == 16'h0000) && !m_tuser[0], "config error result is not zero")

    // A clamped result sits at one of the two limits.
    `CPHU_ASSERT_IMM(a_sat_limit, clk, rst_n, m_tvalid && m_tuser[0], (m_tdata == 16'h7FFF) || (m_tdata == 16'h8000), "saturated result is not at a limit")

    // With the output side taking results, the pipeline never pushes back.
    `CPHU_ASSERT_IMM(a_no_backpressure, clk, rst_n, m_tready, s_tready, "input stalled while output is ready")

    // An accepted sample lands in the decode stage.
    `CPHU_ASSERT_NXT(a_accept_lands, clk, rst_n, s_tvalid && s_tready, dec_valid, "accepted sample lost at decode")

endmodule

`default_nettype wire

// ===== test/tb_ct_pixel_to_hu_converter.sv =====
// Self-checking testbench for the CT pixel to Hounsfield unit converter.
module tb_ct_pixel_to_hu_converter;

    timeunit 1ns;
    timeprecision 1ps;

    import cphu_pkg::*;

    localparam int LATENCY_WAIT   = 12;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 13;
    localparam int PHASE_ITEMS    = 150;

    // One converted sample as it leaves the block.
    typedef struct packed {
        logic signed [15:0] hu;
        logic               sat;
        logic               err;
    } hu_result_t;

    // One row of the directed table.
    typedef struct {
        cphu_cfg_t  cfg;
        logic [15:0] raw;
        bit          known;
        hu_result_t  res;
    } sample_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic        pready;

    // Typed-in expectation that travels beside s_tdata.
    logic        s_known;
    hu_result_t  s_known_res;

    cphu_cfg_t   cfg_now;
    hu_result_t  hu_expected[$];
    sample_row_t sample_rows[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    logic [5:0]  rx_cycle = '0;
    logic [1:0]  rx_mode = '0;

    ct_pixel_to_hu_converter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [15:0] raw_sample
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [15:0] hu_value
        .m_tuser  (m_tuser),   // [0] saturated, [1] config_error
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Expected conversion of one stored word under a given configuration.
    function automatic hu_result_t predict_hu(cphu_cfg_t c, logic [15:0] raw);
        hu_result_t r;
        longint     word;
        longint     masked;
        longint     sample;
        longint     acc;
        longint     mag;
        longint     rnd;
        bit         neg;
        r = '0;
        if ((c.alloc_bits != ALLOC_8 && c.alloc_bits != ALLOC_16) || c.stored_bits == 0 ||
            c.stored_bits > c.alloc_bits || c.sign_mode > SIGN_TWOS)
        begin
            r.err = 1'b1;
            return r;
        end
        word = longint'(raw);
        if (c.alloc_bits == ALLOC_8)
            word = word & 64'hFF;
        masked = word & ((longint'(1) << c.stored_bits) - 1);
        if (c.sign_mode == SIGN_TWOS && masked[c.stored_bits - 1])
            sample = masked - (longint'(1) << c.stored_bits);
        else
            sample = masked;
        acc = sample * longint'(signed'(c.slope)) + longint'(signed'(c.intercept));
        // Round the magnitude half away from zero, then restore the sign and clamp.
        neg = acc < 0;
        mag = neg ? -acc : acc;
        rnd = (mag + (longint'(1) << (FRACTION_BITS_DEF - 1))) >>> FRACTION_BITS_DEF;
        if (neg)
        begin
            if (rnd > HU_NEG_LIMIT)
            begin
                r.hu  = -16'sd32768;
                r.sat = 1'b1;
            end
            else
                r.hu = 16'(-rnd);
        end
        else
        begin
            if (rnd > HU_POS_LIMIT)
            begin
                r.hu  = 16'sd32767;
                r.sat = 1'b1;
            end
            else
                r.hu = 16'(rnd);
        end
        return r;
    endfunction

    function automatic cphu_cfg_t make_cfg(logic [4:0] alloc, logic [4:0] stored,
                                           logic [1:0] sign, logic [31:0] slope,
                                           logic [31:0] intercept);
        cphu_cfg_t c;
        c.alloc_bits  = alloc;
        c.stored_bits = stored;
        c.sign_mode   = sign;
        c.slope       = slope;
        c.intercept   = intercept;
        return c;
    endfunction

    function automatic void add_row(cphu_cfg_t c, logic [15:0] raw, bit known,
                                    int hu = 0, bit sat = 0, bit err = 0);
        sample_row_t row;
        row.cfg     = c;
        row.raw     = raw;
        row.known   = known;
        row.res.hu  = 16'(hu);
        row.res.sat = sat;
        row.res.err = err;
        sample_rows = {sample_rows, row};
    endfunction

    // Random configuration: mostly valid settings, now and then arbitrary fields.
    function automatic cphu_cfg_t random_settings();
        cphu_cfg_t   c;
        logic [31:0] v;
        if ($urandom_range(0, 7) == 0)
        begin
            c.alloc_bits  = 5'($urandom);
            c.stored_bits = 5'($urandom);
            c.sign_mode   = 2'($urandom);
        end
        else
        begin
            c.alloc_bits  = $urandom_range(0, 1) ? ALLOC_16 : ALLOC_8;
            c.stored_bits = 5'($urandom_range(1, c.alloc_bits));
            c.sign_mode   = $urandom_range(0, 1) ? SIGN_TWOS : SIGN_UNSIGNED;
        end
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h0003_FFFF);
            2: v = 32'($urandom_range(1, 4)) << 16;
            default: v = $urandom_range(0, 32'h0000_7FFF) & 32'hFFFF_C000;
        endcase
        c.slope = $urandom_range(0, 1) ? -v : v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h0FFF_FFFF);
            2: v = 32'($urandom_range(0, 255)) << 15;
            default: v = '0;
        endcase
        c.intercept = $urandom_range(0, 1) ? -v : v;
        return c;
    endfunction

    // Register write over the configuration port: setup, then access.
    // The port stays selected so that writes can follow back to back.
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_ALLOC:     cfg_now.alloc_bits  = value[4:0];
            REG_STORED:    cfg_now.stored_bits = value[4:0];
            REG_SIGN:      cfg_now.sign_mode   = value[1:0];
            REG_SLOPE:     cfg_now.slope       = value;
            REG_INTERCEPT: cfg_now.intercept   = value;
            default: ;
        endcase
    endtask

    // Write all registers, then release the configuration port.
    task automatic load_settings(cphu_cfg_t c);
        write_reg(REG_ALLOC, 32'(c.alloc_bits));
        write_reg(REG_STORED, 32'(c.stored_bits));
        write_reg(REG_SIGN, 32'(c.sign_mode));
        write_reg(REG_SLOPE, c.slope);
        write_reg(REG_INTERCEPT, c.intercept);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop sending and let every outstanding result come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (hu_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    // Offer one sample; the sender runs in bursts with random gaps between them.
    task automatic send_sample(logic [15:0] raw, bit known, hu_result_t res);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= raw;
        s_known     <= known;
        s_known_res <= res;
        do @(posedge clk); while (!s_tready);
        burst_left--;
    endtask

    // Receiver stalls follow a mode that is drawn anew each time the 6-bit cycle counter wraps.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 6'd1;
        if (rx_cycle == 6'd0)
            rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= (rx_cycle[1:0] == 2'd0);
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Record expectations on input transfers, check output transfers, watch for hangs.
    always @(posedge clk)
    begin
        hu_result_t got;
        hu_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                hu_expected = {hu_expected,
                               (s_known ? s_known_res : predict_hu(cfg_now, s_tdata))};
            if (m_tvalid && m_tready)
            begin
                got.hu  = m_tdata;
                got.sat = m_tuser[0];
                got.err = m_tuser[1];
                if (hu_expected.size() == 0)
                begin
                    $error("unexpected result transfer: hu_value %0d", got.hu);
                    mismatch_count++;
                end
                else
                begin
                    want = hu_expected.pop_front();
                    if (got.hu !== want.hu)
                    begin
                        $error("hu_value: expected %0d, actual %0d", want.hu, got.hu);
                        mismatch_count++;
                    end
                    if (got.sat !== want.sat)
                    begin
                        $error("saturated: expected %0b, actual %0b", want.sat, got.sat);
                        mismatch_count++;
                    end
                    if (got.err !== want.err)
                    begin
                        $error("config_error: expected %0b, actual %0b", want.err, got.err);
                        mismatch_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, then random phases.
    initial
    begin
        cphu_cfg_t  plain;
        cphu_cfg_t  twos;
        cphu_cfg_t  half;
        cphu_cfg_t  c;
        hu_result_t none;

        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_known     <= 1'b0;
        s_known_res <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        none = '0;
        cfg_now = make_cfg(ALLOC_RESET, STORED_RESET, SIGN_RESET, SLOPE_RESET,
                           INTERCEPT_RESET);

        plain = cfg_now;
        twos  = make_cfg(ALLOC_16, ALLOC_16, SIGN_TWOS, SLOPE_RESET, 32'h0);
        half  = make_cfg(ALLOC_16, ALLOC_16, SIGN_TWOS, 32'h0000_8000, 32'h0);

        // Reset defaults and clamping at both ends.
        add_row(plain, 16'h0000, 1, 0);
        add_row(plain, 16'hFFFF, 1, 32767, 1);
        add_row(plain, 16'h7FFF, 1, 32767);
        add_row(plain, 16'h8000, 1, 32767, 1);
        add_row(twos, 16'h8000, 1, -32768);
        add_row(twos, 16'hFFFF, 1, -1);
        add_row(make_cfg(ALLOC_16, ALLOC_16, SIGN_TWOS, 32'hFFFF_0000, 32'h0),
                16'h8000, 1, 32767, 1);
        add_row(make_cfg(ALLOC_16, ALLOC_16, SIGN_TWOS, 32'h0002_0000, 32'h0),
                16'h8000, 1, -32768, 1);
        // Exact halves round away from zero.
        add_row(half, 16'h0005, 1, 3);
        add_row(half, 16'hFFFB, 1, -3);
        add_row(half, 16'h0003, 1, 2);
        // Eight-bit words, narrow stored widths and sign extension.
        add_row(make_cfg(ALLOC_8, ALLOC_8, SIGN_UNSIGNED, SLOPE_RESET, 32'h0),
                16'hABCD, 1, 205);
        add_row(make_cfg(ALLOC_8, ALLOC_8, SIGN_TWOS, SLOPE_RESET, 32'h0), 16'h12FF, 1, -1);
        add_row(make_cfg(ALLOC_8, 5'd4, SIGN_TWOS, SLOPE_RESET, 32'h0), 16'h00F8, 1, -8);
        add_row(make_cfg(ALLOC_16, STORED_ONE, SIGN_TWOS, SLOPE_RESET, 32'h0),
                16'h0001, 1, -1);
        add_row(make_cfg(ALLOC_16, STORED_ONE, SIGN_UNSIGNED, SLOPE_RESET, 32'h0),
                16'hFFFF, 1, 1);
        // Invalid configurations give zero with the error flag.
        add_row(make_cfg(5'd0, ALLOC_16, SIGN_UNSIGNED, SLOPE_RESET, 32'h0), 16'h1234, 1, 0, 0, 1);
        add_row(make_cfg(5'd12, ALLOC_8, SIGN_UNSIGNED, SLOPE_RESET, 32'h0), 16'h1234, 1, 0, 0, 1);
        add_row(make_cfg(ALLOC_16, 5'd0, SIGN_UNSIGNED, SLOPE_RESET, 32'h0), 16'h1234, 1, 0, 0, 1);
        add_row(make_cfg(ALLOC_16, 5'd17, SIGN_UNSIGNED, SLOPE_RESET, 32'h0), 16'h1234, 1, 0, 0, 1);
        add_row(make_cfg(ALLOC_8, 5'd9, SIGN_UNSIGNED, SLOPE_RESET, 32'h0), 16'h1234, 1, 0, 0, 1);
        add_row(make_cfg(ALLOC_16, ALLOC_16, 2'd2, SLOPE_RESET, 32'h0), 16'h1234, 1, 0, 0, 1);
        add_row(make_cfg(5'd31, 5'd31, 2'd3, SLOPE_RESET, 32'h0), 16'hFFFF, 1, 0, 0, 1);
        // Slope and intercept at their limits.
        add_row(make_cfg(ALLOC_16, ALLOC_16, SIGN_UNSIGNED, 32'h8000_0000, 32'h7FFF_FFFF),
                16'hFFFF, 1, -32768, 1);
        add_row(make_cfg(ALLOC_16, ALLOC_16, SIGN_UNSIGNED, 32'h0, 32'h7FFF_FFFF),
                16'h1234, 1, 32767, 1);
        add_row(make_cfg(ALLOC_16, ALLOC_16, SIGN_UNSIGNED, 32'h0, 32'h8000_0000),
                16'h0000, 1, -32768);
        add_row(make_cfg(ALLOC_16, ALLOC_16, SIGN_TWOS, 32'h7FFF_FFFF, 32'hFFFF_8000),
                16'h1234, 0);
        add_row(make_cfg(ALLOC_16, 5'd12, SIGN_TWOS, 32'h0001_8000, 32'h0012_3456),
                16'h0ABC, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; the first rows run on the reset values of the registers.
        foreach (sample_rows[i])
        begin
            if (sample_rows[i].cfg != cfg_now)
            begin
                drain_results();
                load_settings(sample_rows[i].cfg);
            end
            send_sample(sample_rows[i].raw, sample_rows[i].known, sample_rows[i].res);
        end

        // Random phases, each under a fresh configuration.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            c = random_settings();
            load_settings(c);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 15))
                    0: send_sample(16'h0000, 0, none);
                    1: send_sample(16'hFFFF, 0, none);
                    2: send_sample($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF, 0, none);
                    3: send_sample(16'($urandom_range(16'h0070, 16'h008F)), 0, none);
                    default: send_sample(16'($urandom), 0, none);
                endcase
            end
        end

        drain_results();
        if (hu_expected.size() != 0)
        begin
            $error("%0d expected results never arrived", hu_expected.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cphu_pkg.sv
hdl/cphu_regs.sv
hdl/cphu_decode.sv
hdl/cphu_scale.sv
hdl/cphu_round.sv
hdl/ct_pixel_to_hu_converter.sv
test/tb_ct_pixel_to_hu_converter.sv
